>>> src/order_book_sweep_matcher_assert.svh
// Assertion macros for the order book sweep matcher.
// Define NO_ASSERTIONS to compile them away.
`ifndef ORDER_BOOK_SWEEP_MATCHER_ASSERT_SVH
`define ORDER_BOOK_SWEEP_MATCHER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property checked at every clock edge outside reset.
`define OBSM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define OBSM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define OBSM_ASSERT(lbl, clk, rst, prop, msg)
`define OBSM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

>>> src/obsm_pkg.sv
package obsm_pkg;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_ORDER = 1'b1;

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  localparam logic [1:0] TIF_KEEP = 2'd0;
  localparam logic [1:0] TIF_IOC  = 2'd1;
  localparam logic [1:0] TIF_FOK  = 2'd2;

  localparam logic KIND_FILL    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_ZERO_QTY = 1'b1;

  localparam logic [4:0] UNLIMITED = 5'd0;

  typedef struct packed {
    logic        req_type;
    logic        book_side;
    logic [3:0]  level_index;
    logic        level_is_last;
    logic [31:0] price;
    logic [31:0] quantity;
    logic        has_limit;
    logic [1:0]  time_in_force;
    logic [4:0]  max_levels;
  } req_t;

  typedef struct packed {
    logic        record_kind;
    logic        status;
    logic [31:0] fill_price;
    logic [31:0] fill_quantity;
    logic [31:0] filled_total;
    logic [31:0] remaining;
    logic [4:0]  fill_count;
    logic [63:0] notional;
    logic        last;
  } rec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_DRAIN,
    ST_SUMMARY
  } state_t;

endpackage

>>> src/order_book_sweep_matcher.sv
// Order book sweep matcher.
// Requests arrive on req/req_valid/req_ready, records leave on rec/rec_valid/rec_ready;
// an item moves at a clock edge where valid and ready are both high.
// A load request (req_type 0) writes one bid or ask level into the book RAM
// when its index is in range and optionally sets that side's level count; it
// emits nothing. An order request (req_type 1) sweeps the opposite side best first.
// A decide pass walks the levels, each with a RAM read state and an evaluate
// state, enters the drain state on the check that stops it and waits there
// while the product/accumulate pipeline empties. If fills exist and the order
// is not killed, an emit pass walks the same levels again and drains once more,
// one fill record per level crossed, followed by one summary record.
// The levels are read one at a time through the single read port of the book
// RAM, and the next request is taken only once the summary record is loaded;
// a zero quantity order goes straight to its summary record.
// The output record sits in a register: a stalled receiver holds the walk at
// the next record, while load requests are still taken when the walk is idle.
// Reset empties both books (counts to zero) and drops any pending record;
// the RAM itself needs no clearing pass since levels beyond a count are never read.
module order_book_sweep_matcher #(
  parameter int LEVELS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  obsm_pkg::req_t req,
  input  logic          req_valid,
  output logic          req_ready,
  output obsm_pkg::rec_t rec,
  output logic          rec_valid,
  input  logic          rec_ready
);

  import obsm_pkg::*;

  `include "order_book_sweep_matcher_assert.svh"

  localparam int AW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int CW     = $clog2(LEVELS + 1);
  localparam int RDEPTH = 2 << AW;
  localparam int MW     = AW + 1;

  state_t state, state_next;

  // book side level counts
  logic [CW-1:0] bid_count, ask_count;

  // order context
  req_t          ord;
  logic [CW-1:0] lvl;
  logic [4:0]    nf;
  logic [31:0]   rem;
  logic          pass;
  logic          kill;
  logic          err;

  // notional pipeline
  logic [31:0] take_r, price_r;
  logic [63:0] prod;
  logic [63:0] notional;
  logic        mul_en, acc_en;

  // book RAM
  logic          mem_we;
  logic [MW-1:0] waddr, raddr;
  logic [63:0]   rdata;
  logic [31:0]   lv_price, lv_qty;

  // decode
  logic          req_fire, out_free, idx_ok;
  logic [CW-1:0] new_count, count_sel;
  logic          stop_rd, lim_ok, take_nz;
  logic [31:0]   take;
  logic          eval_step, eval_take, load_fill, load_sum;
  logic          drain_done, restart, kill_set, fok_short;
  logic [64:0]   acc_sum;
  rec_t          fill_rec, sum_rec;

  obsm_ram #(
    .WIDTH(64),
    .DEPTH(RDEPTH)
  ) u_book (
    .clk  (clk),
    .we   (mem_we),
    .waddr(waddr),
    .wdata({req.price, req.quantity}),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign lv_price = rdata[63:32];
  assign lv_qty   = rdata[31:0];

  // Bids live in the low half of the RAM, asks in the high half.
  assign waddr = {req.book_side, AW'(req.level_index)};
  assign raddr = {~ord.book_side, lvl[AW-1:0]};

  assign req_fire  = req_valid && req_ready;
  assign out_free  = !rec_valid || rec_ready;
  assign idx_ok    = 32'(req.level_index) < LEVELS;
  assign new_count = CW'(5'(req.level_index) + 5'd1);

  // A sell sweeps the bids, a buy sweeps the asks.
  assign count_sel = (ord.book_side == SIDE_SELL) ? bid_count : ask_count;

  assign stop_rd = (lvl >= count_sel) || (rem == 32'd0) ||
                   ((ord.max_levels != UNLIMITED) && (nf >= ord.max_levels));

  assign lim_ok = !ord.has_limit ||
                  ((ord.book_side == SIDE_SELL) ? (lv_price >= ord.price)
                                                : (lv_price <= ord.price));

  assign take    = (lv_qty < rem) ? lv_qty : rem;
  assign take_nz = take != 32'd0;

  assign fok_short  = (ord.time_in_force == TIF_FOK) && (rem != 32'd0);
  assign drain_done = (state == ST_DRAIN) && !mul_en && !acc_en;
  assign restart    = drain_done && !pass && !fok_short && (nf != 5'd0);
  assign kill_set   = drain_done && !pass && fok_short;

  assign acc_sum = {1'b0, notional} + {1'b0, prod};

  always_comb begin
    fill_rec                = '0;
    fill_rec.record_kind    = KIND_FILL;
    fill_rec.status         = STATUS_OK;
    fill_rec.fill_price     = lv_price;
    fill_rec.fill_quantity  = take;
    fill_rec.last           = 1'b0;
  end

  always_comb begin
    sum_rec             = '0;
    sum_rec.record_kind = KIND_SUMMARY;
    sum_rec.last        = 1'b1;
    if (err) begin
      sum_rec.status = STATUS_ZERO_QTY;
    end else if (kill) begin
      sum_rec.status    = STATUS_OK;
      sum_rec.remaining = ord.quantity;
    end else begin
      sum_rec.status       = STATUS_OK;
      sum_rec.filled_total = ord.quantity - rem;
      sum_rec.remaining    = (ord.time_in_force == TIF_IOC) ? 32'd0 : rem;
      sum_rec.fill_count   = nf;
      sum_rec.notional     = notional;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_fire && req.req_type == REQ_ORDER) begin
          state_next = (req.quantity == 32'd0) ? ST_SUMMARY : ST_READ;
        end
      end
      ST_READ: begin
        state_next = stop_rd ? ST_DRAIN : ST_EVAL;
      end
      ST_EVAL: begin
        if (!lim_ok) begin
          state_next = ST_DRAIN;
        end else if (eval_step) begin
          state_next = ST_READ;
        end
      end
      ST_DRAIN: begin
        if (drain_done) begin
          state_next = restart ? ST_READ : ST_SUMMARY;
        end
      end
      ST_SUMMARY: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    req_ready = 1'b0;
    mem_we    = 1'b0;
    eval_step = 1'b0;
    eval_take = 1'b0;
    load_fill = 1'b0;
    load_sum  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        mem_we    = req_valid && req.req_type == REQ_LOAD && idx_ok;
      end
      ST_EVAL: begin
        if (lim_ok) begin
          eval_step = !take_nz || !pass || out_free;
          eval_take = take_nz && (!pass || out_free);
          load_fill = take_nz && pass && out_free;
        end
      end
      ST_SUMMARY: begin
        load_sum = out_free;
      end
      ST_READ, ST_DRAIN: begin
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      bid_count <= '0;
      ask_count <= '0;
      rec_valid <= 1'b0;
      mul_en    <= 1'b0;
      acc_en    <= 1'b0;
    end else begin
      state <= state_next;
      if (mem_we && req.level_is_last) begin
        if (req.book_side) begin
          ask_count <= new_count;
        end else begin
          bid_count <= new_count;
        end
      end
      // only the decide pass feeds the notional pipeline
      mul_en <= eval_take && !pass;
      acc_en <= mul_en;
      if (load_fill || load_sum) begin
        rec_valid <= 1'b1;
      end else if (rec_ready) begin
        rec_valid <= 1'b0;
      end
    end
  end

  // order datapath
  always_ff @(posedge clk) begin
    if (req_fire && req.req_type == REQ_ORDER) begin
      ord      <= req;
      lvl      <= '0;
      nf       <= 5'd0;
      rem      <= req.quantity;
      pass     <= 1'b0;
      kill     <= 1'b0;
      err      <= req.quantity == 32'd0;
      notional <= '0;
    end else begin
      if (eval_step) begin
        lvl <= lvl + CW'(1);
      end
      if (eval_take) begin
        rem     <= rem - take;
        nf      <= nf + 5'd1;
        take_r  <= take;
        price_r <= lv_price;
      end
      if (acc_en) begin
        // saturate on carry out
        notional <= acc_sum[64] ? '1 : acc_sum[63:0];
      end
      if (restart) begin
        // replay the sweep to emit fills
        pass <= 1'b1;
        lvl  <= '0;
        nf   <= 5'd0;
        rem  <= ord.quantity;
      end
      if (kill_set) begin
        kill <= 1'b1;
      end
    end
    if (mul_en) begin
      prod <= 64'(price_r) * 64'(take_r);
    end
    if (load_fill) begin
      rec <= fill_rec;
    end else if (load_sum) begin
      rec <= sum_rec;
    end
  end

  `OBSM_ASSERT(a_no_overwrite, clk, rst, (load_fill || load_sum) |-> out_free, "record overwritten while stalled")
  `OBSM_ASSERT_NEXT(a_summary_last, clk, rst, load_sum, rec_valid && rec.last && rec.record_kind == KIND_SUMMARY, "summary not presented as last")
  `OBSM_ASSERT(a_fill_nonzero, clk, rst, (rec_valid && rec.record_kind == KIND_FILL) |-> rec.fill_quantity != 32'd0, "fill with zero quantity")
  `OBSM_ASSERT(a_cap_held, clk, rst, (state != ST_IDLE && ord.max_levels != UNLIMITED) |-> nf <= ord.max_levels, "level cap exceeded")

endmodule

>>> src/obsm_ram.sv
module obsm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
